// File: sv/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the positional list store
// Command and status codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 8;
  localparam int ST_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_TRAVERSE  = 3'd6
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_TRAV = 1'b1
  } state_t;

endpackage
`default_nettype wire

// File: sv/positional_list_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list of signed 32-bit values
// Insert/delete at front, back or a 1-based position, and in-order traverse.
// ----------------------------------------------------------------------------
// A command transfers on a rising edge with start high and busy low. Every
// command other than traverse is done at that edge: the whole row of
// cells shifts in parallel, busy stays low and one status result appears on
// the next cycle with last set, so a new command may transfer on the very
// next edge. A traverse of a list of N elements holds busy high in S_TRAV,
// during which the occupied cells rotate by one per cycle so that the head
// cell always holds the element to emit, and the list is back in its
// original order when the last one leaves. The N results come back to back
// one register stage later; busy is already low while the last one is shown,
// so the next command can transfer at the edge that takes it. A traverse of
// an empty list gives a single empty status result on the next cycle and
// does not raise busy. Results are held for exactly one cycle, marked by
// valid; the receiver cannot stall them, so it must take every one. Status:
// 0 ok, 1 full, 2 empty, 3 bad position.
// ----------------------------------------------------------------------------
module positional_list_store
  import pls_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire  [CMD_W-1:0]    cmd,
  input  wire  [VALUE_W-1:0]  value,
  input  wire  [POS_W-1:0]    position,
  output logic                valid,
  output logic [VALUE_W-1:0]  item_value,
  output logic [CNT_W-1:0]    item_index,
  output logic [ST_W-1:0]     status,
  output logic                last
);

  // compare width wide enough for both the position field and count + 1
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    trav_idx, trav_idx_next;

  logic                valid_next;
  logic [VALUE_W-1:0]  item_value_next;
  logic [CNT_W-1:0]    item_index_next;
  status_t             status_next;
  logic                last_next;

  cell_op_t            cell_op;
  logic [CNT_W-1:0]    slot;
  cmd_t                cmd_c;
  logic                is_full, is_empty;
  logic [CMP_W-1:0]    pos_ext, cnt_ext;
  logic [CNT_W-1:0]    trav_idx_inc;

  logic [VALUE_W-1:0]  cell_data [CAPACITY];

  // --------------------------------------------------------------------------
  // Row of cells; each one sees its left and right neighbor and the head.
  // --------------------------------------------------------------------------
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [VALUE_W-1:0] left_d, right_d;
    if (gi == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_data[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[gi];
    end else begin : g_mid_r
      assign right_d = cell_data[gi+1];
    end
    pls_cell #(
      .INDEX (gi),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .slot       (slot),
      .cnt        (count),
      .ins_value  (value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data       (cell_data[gi])
    );
  end

  assign cmd_c        = cmd_t'(cmd);
  assign is_full      = (count == FULL_CNT);
  assign is_empty     = (count == '0);
  assign pos_ext      = CMP_W'(position);
  assign cnt_ext      = CMP_W'(count);
  assign trav_idx_inc = trav_idx + CNT_W'(1);
  assign busy         = (state == S_TRAV);

  // --------------------------------------------------------------------------
  // Next state, cell op and the result to register
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    count_next      = count;
    trav_idx_next   = trav_idx;
    cell_op         = CELL_HOLD;
    slot            = '0;
    valid_next      = 1'b0;
    item_value_next = '0;
    item_index_next = '0;
    status_next     = ST_OK;
    last_next       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          valid_next = 1'b1;
          last_next  = 1'b1;
          unique case (cmd_c) inside
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (is_full) begin
                status_next = ST_FULL;
              end else begin
                cell_op    = CELL_INS;
                slot       = (cmd_c == CMD_INS_FRONT) ? '0 : count;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_INS_POS: begin
              if (is_full) begin
                status_next = ST_FULL;
              end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                status_next = ST_BADPOS;
              end else begin
                cell_op    = CELL_INS;
                slot       = CNT_W'(position - POS_W'(1));
                count_next = count + CNT_W'(1);
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                cell_op    = CELL_DEL;
                slot       = (cmd_c == CMD_DEL_FRONT) ? '0 : count - CNT_W'(1);
                count_next = count - CNT_W'(1);
              end
            end
            CMD_DEL_POS: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                status_next = ST_BADPOS;
              end else begin
                cell_op    = CELL_DEL;
                slot       = CNT_W'(position - POS_W'(1));
                count_next = count - CNT_W'(1);
              end
            end
            CMD_TRAVERSE: begin
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                // results come from the rotating head while in S_TRAV
                valid_next    = 1'b0;
                last_next     = 1'b0;
                trav_idx_next = '0;
                state_next    = S_TRAV;
              end
            end
            default: begin
              // unused code: plain ok result, list untouched
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_TRAV: begin
        // emit the head, rotate the occupied cells, advance the index
        cell_op         = CELL_ROT;
        valid_next      = 1'b1;
        item_value_next = cell_data[0];
        item_index_next = trav_idx_inc;
        last_next       = (trav_idx_inc == count);
        trav_idx_next   = trav_idx_inc;
        if (trav_idx_inc == count) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      trav_idx <= '0;
      valid    <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      trav_idx <= trav_idx_next;
      valid    <= valid_next;
    end
  end

  // result payload: hold no reset, qualified by valid
  always_ff @(posedge clk) begin
    item_value <= item_value_next;
    item_index <= item_index_next;
    status     <= status_next;
    last       <= last_next;
  end

endmodule
`default_nettype wire

// File: sv/pls_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list
// Holds one element and loads from the new value, a neighbor or the head per op.
// ----------------------------------------------------------------------------
module pls_cell
  import pls_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  wire                      clk,
  input  cell_op_t                 op,
  input  wire  [CNT_W-1:0]         slot,
  input  wire  [CNT_W-1:0]         cnt,
  input  wire  [VALUE_W-1:0]       ins_value,
  input  wire  [VALUE_W-1:0]       left_data,
  input  wire  [VALUE_W-1:0]       right_data,
  input  wire  [VALUE_W-1:0]       head_data,
  output logic [VALUE_W-1:0]       data
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);

  logic [VALUE_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (op)
      CELL_INS: begin
        if (MY_IDX == slot) begin
          data_next = ins_value;
        end else if (MY_IDX > slot) begin
          data_next = left_data;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= slot) begin
          data_next = right_data;
        end
      end
      CELL_ROT: begin
        // rotate the occupied cells toward the head; the tail takes the head
        if (MY_NEXT < cnt) begin
          data_next = right_data;
        end else if (MY_NEXT == cnt) begin
          data_next = head_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

// File: sv/pls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_checker: port-level checks for the positional list store
// Watches command transfers and result timing seen on the top level ports.
// ----------------------------------------------------------------------------
module pls_checker
  import pls_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input wire                clk,
  input wire                rst,
  input wire                start,
  input wire                busy,
  input wire [CMD_W-1:0]    cmd,
  input wire                valid,
  input wire [VALUE_W-1:0]  item_value,
  input wire [CNT_W-1:0]    item_index,
  input wire [ST_W-1:0]     status,
  input wire                last
);

  // every transfer yields a result next cycle, or starts a traverse
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (valid || busy))
    else $error("no result after command transfer");

  // traverse results come back to back until last
  a_trav_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> valid)
    else $error("gap in traverse results");

  // busy only rises after a traverse transfer
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && cmd == CMD_TRAVERSE))
    else $error("busy rose without traverse");

  // an error status carries no element
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (valid && status != ST_OK) |-> (last && item_index == '0 && item_value == '0))
    else $error("error result carries element data");

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd        (cmd),
  .valid      (valid),
  .item_value (item_value),
  .item_index (item_index),
  .status     (status),
  .last       (last)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list store
// Sends list commands through the start/busy handshake. A shadow copy of the
// list predicts every status and every traversed element. Each result strobe
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pls_pkg::*;

  localparam int               LIST_DEPTH   = CAPACITY_DEF;
  localparam int               IDX_W        = $clog2(LIST_DEPTH + 1);
  // Code seven is outside the enum; the block must ignore it with one result.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;
  localparam logic [VALUE_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam int               RANDOM_ITEMS = 350;
  localparam int               CALM_TAIL    = 60;   // last transfers go back to back
  localparam int               PHASE_LEN    = 48;   // grow / shrink / mixed rotation
  localparam int               DRAIN_LIMIT  = 2000;
  localparam int               PRINT_CAP    = 100;

  typedef struct packed {
    logic [VALUE_W-1:0] item_value;
    logic [IDX_W-1:0]   item_index;
    status_t            status;
    logic               last;
  } list_result_t;

  // Shadow of the list contents plus the queue of results it predicts.
  class list_shadow;
    logic [VALUE_W-1:0] cells [LIST_DEPTH];
    int unsigned        fill;
    list_result_t       pending_results [$];
    int unsigned        mismatches;
    int unsigned        accepted;
    int unsigned        checked;
    int unsigned        traversals;
    int unsigned        deepest;
    int unsigned        status_seen [4];

    task report(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task push_expect(input logic [VALUE_W-1:0] v, input int unsigned idx,
                     input status_t st, input logic lst);
      list_result_t r;
      r.item_value = v;
      r.item_index = IDX_W'(idx);
      r.status     = st;
      r.last       = lst;
      pending_results.push_back(r);
    endtask

    // Apply one accepted command to the shadow list and queue its results.
    task apply_command(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v,
                       input logic [POS_W-1:0] pos);
      status_t     st;
      int unsigned slot;
      int          i;
      st   = ST_OK;
      slot = 0;
      accepted++;
      case (op)
        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
          // Full wins over a bad position.
          if (fill >= LIST_DEPTH) st = ST_FULL;
          else if (op == CMD_INS_POS && (pos < 1 || pos > fill + 1)) st = ST_BADPOS;
          else begin
            if (op == CMD_INS_BACK) slot = fill;
            else if (op == CMD_INS_POS) slot = pos - 1;
            for (i = fill; i > slot; i--) cells[i] = cells[i - 1];
            cells[slot] = v;
            fill++;
            if (fill > deepest) deepest = fill;
          end
        end
        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
          // Empty wins over a bad position.
          if (fill == 0) st = ST_EMPTY;
          else if (op == CMD_DEL_POS && (pos < 1 || pos > fill)) st = ST_BADPOS;
          else begin
            if (op == CMD_DEL_BACK) slot = fill - 1;
            else if (op == CMD_DEL_POS) slot = pos - 1;
            for (i = slot; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
          end
        end
        CMD_TRAVERSE: begin
          traversals++;
          if (fill == 0) st = ST_EMPTY;
          else begin
            for (i = 0; i < fill; i++) push_expect(cells[i], i + 1, ST_OK, i + 1 == fill);
            return;
          end
        end
        default: ;
      endcase
      push_expect('0, 0, st, 1'b1);
    endtask

    // Compare one result strobe with the oldest prediction.
    task check_result(input logic [VALUE_W-1:0] v, input logic [IDX_W-1:0] idx,
                      input logic [ST_W-1:0] st, input logic lst);
      list_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result: value %0d index %0d status %0d last %0b",
                         $signed(v), idx, st, lst));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      status_seen[want.status]++;
      if (v !== want.item_value)
        report($sformatf("item_value %0d, want %0d", $signed(v), $signed(want.item_value)));
      if (idx !== want.item_index)
        report($sformatf("item_index %0d, want %0d", idx, want.item_index));
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (lst !== want.last)
        report($sformatf("last %0b, want %0b", lst, want.last));
    endtask
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 start    = 1'b0;
  logic [CMD_W-1:0]     cmd      = '0;
  logic [VALUE_W-1:0]   value    = '0;
  logic [POS_W-1:0]     position = '0;
  wire                  busy;
  wire                  valid;
  wire  [VALUE_W-1:0]   item_value;
  wire  [IDX_W-1:0]     item_index;
  wire  [ST_W-1:0]      status;
  wire                  last;

  list_shadow shadow = new;

  positional_list_store #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .value     (value),
    .position  (position),
    .valid     (valid),
    .item_value(item_value),
    .item_index(item_index),
    .status    (status),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake or the result stream hangs.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Take every result strobe; the receiver has no way to stall.
  always @(posedge clk) begin
    if (!rst && valid) shadow.check_result(item_value, item_index, status, last);
  end

  // Present one command and hold it until a transfer happens (start high,
  // busy low at the edge). Call only right after a rising edge.
  task automatic issue(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v,
                       input logic [POS_W-1:0] pos);
    start    <= 1'b1;
    cmd      <= op;
    value    <= v;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.apply_command(op, v, pos);
  endtask

  // Drop start and idle; scramble the payload so it must be ignored.
  task automatic hold_off(input int n);
    start    <= 1'b0;
    cmd      <= CMD_W'($urandom);
    value    <= $urandom;
    position <= POS_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Random commands in rotating phases: grow the list toward full, shrink it
  // toward empty, then mix. Positions cluster on the legal range and its edges.
  task automatic run_random(input int total);
    int                 n;
    int                 r;
    int                 ins_pct;
    int unsigned        span;
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   pos;
    for (n = 0; n < total; n++) begin
      case ((n / PHASE_LEN) % 3)
        0:       ins_pct = 66;
        1:       ins_pct = 22;
        default: ins_pct = 44;
      endcase
      r = $urandom_range(99);
      if (r < 3) op = CMD_RESERVED;
      else if (r < 12) op = CMD_TRAVERSE;
      else if (r < 12 + ins_pct) op = CMD_W'($urandom_range(CMD_INS_POS, CMD_INS_FRONT));
      else op = CMD_W'($urandom_range(CMD_DEL_POS, CMD_DEL_FRONT));

      case ($urandom_range(9))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = $urandom_range(1) ? '0 : '1;
        default: v = $urandom;
      endcase

      // Legal span: 1..fill+1 for insert, 1..fill for delete.
      span = (op == CMD_INS_POS) ? shadow.fill + 1 : ((shadow.fill == 0) ? 1 : shadow.fill);
      case ($urandom_range(9))
        0:       pos = '0;
        1:       pos = POS_W'($urandom);
        2:       pos = POS_W'(span + 1);
        default: pos = POS_W'($urandom_range(span, 1));
      endcase

      // Idle in bursts, but leave quiet stretches and a back-to-back tail.
      if (n < total - CALM_TAIL && ((n / 20) % 4) != 3 && $urandom_range(3) == 0)
        hold_off($urandom_range(10, 1));
      issue(op, v, pos);
    end
  endtask

  initial begin
    int           guard;
    list_result_t leftover;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: traverse and every delete report empty, even with position 0.
    issue(CMD_TRAVERSE,  '0, '0);
    issue(CMD_DEL_FRONT, '0, '0);
    issue(CMD_DEL_BACK,  '0, '0);
    issue(CMD_DEL_POS,   '0, '0);
    // Append to an empty list, then delete back from a single element.
    issue(CMD_INS_BACK,  VAL_MIN, '0);
    issue(CMD_DEL_BACK,  '0, '0);
    // Position 1 into an empty list, then out-of-range positions.
    issue(CMD_INS_POS,   VAL_MAX, 8'd1);
    issue(CMD_INS_POS,   '1, 8'd0);
    issue(CMD_INS_POS,   '1, 8'd255);
    issue(CMD_INS_POS,   '1, 8'd3);
    // Append via position count+1, insert front, insert in the middle.
    issue(CMD_INS_POS,   '0, 8'd2);
    issue(CMD_INS_FRONT, '1, 8'd255);
    issue(CMD_INS_POS,   32'h1234_5678, 8'd2);
    issue(CMD_TRAVERSE,  '0, '0);
    // Gap right behind a traverse so idling lands on the busy window.
    hold_off(3);
    issue(CMD_DEL_POS,   '0, 8'd0);
    issue(CMD_DEL_POS,   '0, 8'd5);
    issue(CMD_DEL_POS,   '0, 8'd2);
    issue(CMD_DEL_POS,   '0, 8'd3);
    issue(CMD_RESERVED,  '1, 8'd255);
    issue(CMD_DEL_FRONT, '0, '0);
    issue(CMD_TRAVERSE,  '0, '0);
    issue(CMD_DEL_BACK,  '0, '0);
    issue(CMD_TRAVERSE,  '0, '0);

    run_random(RANDOM_ITEMS);
    start <= 1'b0;

    // Drain: wait for every predicted result, then watch for strays.
    guard = 0;
    while (shadow.pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (2 * LIST_DEPTH) @(posedge clk);
    while (shadow.pending_results.size() != 0) begin
      leftover = shadow.pending_results.pop_front();
      shadow.report($sformatf("missing result: value %0d index %0d status %0d last %0b",
                              $signed(leftover.item_value), leftover.item_index,
                              leftover.status, leftover.last));
    end

    $display("Summary: %0d commands sent, %0d results checked, %0d traversals, peak depth %0d/%0d",
             shadow.accepted, shadow.checked, shadow.traversals, shadow.deepest, LIST_DEPTH);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, bad position %0d",
             shadow.status_seen[ST_OK], shadow.status_seen[ST_FULL],
             shadow.status_seen[ST_EMPTY], shadow.status_seen[ST_BADPOS]);
    if (shadow.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pls_pkg.sv
sv/pls_cell.sv
sv/positional_list_store.sv
sv/pls_checker.sv
dv/tb_top.sv
